FILE: design/mbe_pkg.sv
// Shared types, constants and register map for the Mandelbrot escape-time block.
package mbe_pkg;

	// Fixed field widths
	localparam int COORD_FIELD_W = 12;
	localparam int STEP_W        = 24;
	localparam int ORIGIN_W      = 32;
	localparam int COUNT_FIELD_W = 16;
	localparam int DATA_W        = 32;
	localparam int ADDR_W        = 5;
	localparam int REG_IDX_W     = ADDR_W - 2;

	// Parameter defaults
	localparam int DEF_COORD_WIDTH = 12;
	localparam int DEF_FRAC_BITS   = 28;
	localparam int DEF_COUNT_WIDTH = 16;
	localparam int DEF_QUEUE_DEPTH = 4;

	// Register indexes (byte address / 4)
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_REAL    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_IMAG    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_STEP_REAL      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_STEP_IMAG      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MAX_ITERATIONS = 3'd4;

	// Register reset values
	localparam logic signed [ORIGIN_W-1:0] RST_ORIGIN_REAL = -32'sd200333382;
	localparam logic signed [ORIGIN_W-1:0] RST_ORIGIN_IMAG = 32'sd29581587;
	localparam logic [STEP_W-1:0]          RST_STEP_REAL   = 24'd1311;
	localparam logic [STEP_W-1:0]          RST_STEP_IMAG   = 24'd1311;
	localparam logic [COUNT_FIELD_W-1:0]   RST_MAX_ITER    = 16'd500;

	// Saturation bounds of one part of c
	localparam logic signed [ORIGIN_W-1:0] C_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [ORIGIN_W-1:0] C_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [COORD_FIELD_W-1:0] column;
		logic [COORD_FIELD_W-1:0] row;
	} pixel_t;

	typedef struct packed {
		logic [COUNT_FIELD_W-1:0] iteration_count;
		logic                     escaped;
	} result_t;

	typedef struct packed {
		logic signed [ORIGIN_W-1:0] re;
		logic signed [ORIGIN_W-1:0] im;
	} c_point_t;

	typedef enum logic [1:0] {
		IT_IDLE,
		IT_MUL,
		IT_ADD
	} iter_state_t;

endpackage

FILE: design/mandelbrot_escape_time.sv
// Mandelbrot escape-time block: top level with register file, front, queue and engine.
//
// Usage:
//   A pixel transaction (column, row) enters on pixel/pixel_valid/pixel_ready. The front
//   forms c = origin + index * step per axis, saturated to signed Q4.28, and pushes it into
//   a small queue. The engine pops c, iterates z <- z*z + c from zero and presents one
//   result transaction (iteration_count, escaped) on result/result_valid/result_ready.
//   Registers (origin, step, iteration limit) sit on the APB-style port at 4*index; write
//   them only while the block is empty.
// Iteration:
//   Each iteration passes through a multiply state, which forms x*x, y*y and x*y in the
//   three multipliers, and an add state, which adds c and tests for escape. The
//   squared-magnitude test of a new z reuses the products of the following pass, so an
//   escape that shows only in |z|^2 costs the engine an extra pass. The front keeps
//   accepting pixels until its stage and the queue are full, so pixels stream while one
//   iterates.
// Reset and stall:
//   Reset empties the front, queue and engine and loads the default registers. A stalled
//   receiver holds the result in the output register; the engine finishes its pixel, waits
//   for that register to drain, and the queue absorbs further pixels meanwhile.
module mandelbrot_escape_time #(
	parameter int COORD_WIDTH = mbe_pkg::DEF_COORD_WIDTH,
	parameter int FRAC_BITS   = mbe_pkg::DEF_FRAC_BITS,
	parameter int COUNT_WIDTH = mbe_pkg::DEF_COUNT_WIDTH,
	parameter int QUEUE_DEPTH = mbe_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mbe_pkg::pixel_t             pixel,
	input  logic                        pixel_valid,
	output logic                        pixel_ready,
	output mbe_pkg::result_t            result,
	output logic                        result_valid,
	input  logic                        result_ready,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mbe_pkg::ADDR_W-1:0]  paddr,
	input  logic [mbe_pkg::DATA_W-1:0]  pwdata,
	output logic [mbe_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import mbe_pkg::*;

	logic signed [ORIGIN_W-1:0] origin_real_q;
	logic signed [ORIGIN_W-1:0] origin_imag_q;
	logic [STEP_W-1:0]          step_real_q;
	logic [STEP_W-1:0]          step_imag_q;
	logic [COUNT_WIDTH-1:0]     max_iter_q;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 reg_wr;

	c_point_t                 front_point;
	logic                     front_valid;
	logic                     q_full;
	logic                     q_empty;
	logic                     q_pop;
	logic [$bits(c_point_t)-1:0] q_rd_data;

	// Register port: no wait states
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite;

	// Write the addressed register in the access phase; drop writes to unused slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_real_q <= RST_ORIGIN_REAL;
			origin_imag_q <= RST_ORIGIN_IMAG;
			step_real_q   <= RST_STEP_REAL;
			step_imag_q   <= RST_STEP_IMAG;
			max_iter_q    <= RST_MAX_ITER[COUNT_WIDTH-1:0];
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_ORIGIN_REAL:    origin_real_q <= pwdata;
				REG_ORIGIN_IMAG:    origin_imag_q <= pwdata;
				REG_STEP_REAL:      step_real_q   <= pwdata[STEP_W-1:0];
				REG_STEP_IMAG:      step_imag_q   <= pwdata[STEP_W-1:0];
				REG_MAX_ITERATIONS: max_iter_q    <= pwdata[COUNT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register; unused slots read zero
	always_comb begin
		unique case (reg_idx)
			REG_ORIGIN_REAL:    prdata = origin_real_q;
			REG_ORIGIN_IMAG:    prdata = origin_imag_q;
			REG_STEP_REAL:      prdata = DATA_W'(step_real_q);
			REG_STEP_IMAG:      prdata = DATA_W'(step_imag_q);
			REG_MAX_ITERATIONS: prdata = DATA_W'(max_iter_q);
			default:            prdata = '0;
		endcase
	end

	// Front: pixel transaction to saturated c
	mbe_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixel),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.origin_real(origin_real_q),
		.origin_imag(origin_imag_q),
		.step_real  (step_real_q),
		.step_imag  (step_imag_q),
		.point      (front_point),
		.point_valid(front_valid),
		.point_ready(!q_full)
	);

	// Queue: decouple the front from the long-running engine
	mbe_fifo #(
		.WIDTH($bits(c_point_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_valid),
		.wr_data(front_point),
		.full   (q_full),
		.pop    (q_pop),
		.rd_data(q_rd_data),
		.empty  (q_empty)
	);

	// Engine: iterate and hold the result until taken
	mbe_iter #(
		.FRAC_BITS  (FRAC_BITS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_iter (
		.clk           (clk),
		.arst_n        (arst_n),
		.point         (q_rd_data),
		.point_valid   (!q_empty),
		.point_pop     (q_pop),
		.max_iterations(max_iter_q),
		.result        (result),
		.result_valid  (result_valid),
		.result_ready  (result_ready)
	);

endmodule

FILE: design/mbe_fifo.sv
// Small flip-flop queue between the front and the iteration engine.
module mbe_fifo #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int AW   = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/mbe_front.sv
// Front end: accept pixels and map them to the saturated complex point c.
module mbe_front #(
	parameter int COORD_WIDTH = mbe_pkg::DEF_COORD_WIDTH
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  mbe_pkg::pixel_t                          pixel,
	input  logic                                     pixel_valid,
	output logic                                     pixel_ready,
	input  logic signed [mbe_pkg::ORIGIN_W-1:0]      origin_real,
	input  logic signed [mbe_pkg::ORIGIN_W-1:0]      origin_imag,
	input  logic [mbe_pkg::STEP_W-1:0]               step_real,
	input  logic [mbe_pkg::STEP_W-1:0]               step_imag,
	output mbe_pkg::c_point_t                        point,
	output logic                                     point_valid,
	input  logic                                     point_ready
);
	import mbe_pkg::*;

	localparam int CW = (COORD_WIDTH < COORD_FIELD_W) ? COORD_WIDTH : COORD_FIELD_W;
	localparam int PW = CW + STEP_W;
	localparam int SW = ((PW + 1 > ORIGIN_W) ? PW + 1 : ORIGIN_W) + 1;
	localparam logic signed [SW-1:0] SAT_HI = SW'(C_MAX);
	localparam logic signed [SW-1:0] SAT_LO = SW'(C_MIN);

	logic          valid_s1;
	logic [PW-1:0] prod_re_s1;
	logic [PW-1:0] prod_im_s1;
	logic          load;
	logic signed [SW-1:0] sum_re;
	logic signed [SW-1:0] sum_im;

	function automatic logic signed [ORIGIN_W-1:0] sat_c(input logic signed [SW-1:0] v);
		priority if (v > SAT_HI) begin
			return C_MAX;
		end else if (v < SAT_LO) begin
			return C_MIN;
		end else begin
			return v[ORIGIN_W-1:0];
		end
	endfunction

	assign pixel_ready = !valid_s1 || point_ready;
	assign load        = pixel_valid && pixel_ready;
	assign point_valid = valid_s1;

	// Offset products of this pixel
	always_ff @(posedge clk) begin
		if (load) begin
			prod_re_s1 <= pixel.column[CW-1:0] * step_real;
			prod_im_s1 <= pixel.row[CW-1:0] * step_imag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel_ready) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_comb begin
		sum_re   = SW'(origin_real) + signed'(SW'(prod_re_s1));
		sum_im   = SW'(origin_imag) + signed'(SW'(prod_im_s1));
		point.re = sat_c(sum_re);
		point.im = sat_c(sum_im);
	end

endmodule

FILE: design/mbe_iter.sv
// Iteration engine: z <- z*z + c with escape tests and a result register.
module mbe_iter #(
	parameter int FRAC_BITS   = mbe_pkg::DEF_FRAC_BITS,
	parameter int COUNT_WIDTH = mbe_pkg::DEF_COUNT_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mbe_pkg::c_point_t      point,
	input  logic                   point_valid,
	output logic                   point_pop,
	input  logic [COUNT_WIDTH-1:0] max_iterations,
	output mbe_pkg::result_t       result,
	output logic                   result_valid,
	input  logic                   result_ready
);
	import mbe_pkg::*;

	localparam int XW  = FRAC_BITS + 3;
	localparam int PRW = 2 * XW;
	localparam int NW  = ((FRAC_BITS + 5 > ORIGIN_W) ? FRAC_BITS + 5 : ORIGIN_W) + 1;
	localparam logic [PRW:0]           FOUR_SQ = (PRW + 1)'(1) << (2 * FRAC_BITS + 2);
	localparam logic signed [NW-1:0]   TWO_P   = NW'(1) << (FRAC_BITS + 1);
	localparam logic signed [NW-1:0]   TWO_N   = -TWO_P;

	iter_state_t state_q, state_d;

	logic signed [ORIGIN_W-1:0] cre_q;
	logic signed [ORIGIN_W-1:0] cim_q;
	logic signed [XW-1:0]       x_q;
	logic signed [XW-1:0]       y_q;
	logic signed [PRW-1:0]      p_xx_q;
	logic signed [PRW-1:0]      p_yy_q;
	logic signed [PRW-1:0]      p_xy_q;
	logic [COUNT_WIDTH-1:0]     n_q;
	logic                       res_valid_q;
	result_t                    res_q;

	logic signed [PRW:0]    diff;
	logic signed [PRW:0]    re_sh;
	logic signed [PRW-1:0]  im_sh;
	logic signed [NW-1:0]   nx;
	logic signed [NW-1:0]   ny;
	logic [PRW:0]           sq_sum;
	logic                   sq_esc;
	logic                   rng_esc;
	logic                   res_free;
	logic                   load;
	logic                   mul_en;
	logic                   adv;
	logic                   fin;
	logic [COUNT_WIDTH-1:0] fin_count;
	logic                   fin_esc;

	assign result       = res_q;
	assign result_valid = res_valid_q;
	assign res_free     = !res_valid_q || result_ready;

	// New z from the registered products; |z|^2 of the current z from the same products
	always_comb begin
		diff    = (PRW + 1)'(p_xx_q) - (PRW + 1)'(p_yy_q);
		re_sh   = diff >>> FRAC_BITS;
		im_sh   = p_xy_q >>> (FRAC_BITS - 1);
		nx      = signed'(re_sh[NW-1:0]) + NW'(cre_q);
		ny      = signed'(im_sh[NW-1:0]) + NW'(cim_q);
		rng_esc = (nx > TWO_P) || (nx < TWO_N) || (ny > TWO_P) || (ny < TWO_N);
		sq_sum  = (PRW + 1)'(p_xx_q) + (PRW + 1)'(p_yy_q);
		sq_esc  = (sq_sum > FOUR_SQ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		point_pop = 1'b0;
		load      = 1'b0;
		mul_en    = 1'b0;
		adv       = 1'b0;
		fin       = 1'b0;
		fin_count = n_q;
		fin_esc   = 1'b0;
		unique case (state_q)
			IT_IDLE: begin
				if (point_valid) begin
					point_pop = 1'b1;
					load      = 1'b1;
					state_d   = IT_MUL;
				end
			end
			IT_MUL: begin
				mul_en  = 1'b1;
				state_d = IT_ADD;
			end
			IT_ADD: begin
				priority if (sq_esc) begin
					fin       = 1'b1;
					fin_count = n_q - 1'b1;
					fin_esc   = 1'b1;
				end else if (n_q == max_iterations) begin
					fin = 1'b1;
				end else if (rng_esc) begin
					fin     = 1'b1;
					fin_esc = 1'b1;
				end else begin
					adv     = 1'b1;
					state_d = IT_MUL;
				end
				if (fin && res_free) begin
					state_d = IT_IDLE;
				end
			end
			default: begin
				state_d = IT_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cre_q <= point.re;
			cim_q <= point.im;
			x_q   <= '0;
			y_q   <= '0;
			n_q   <= '0;
		end else if (adv) begin
			x_q <= nx[XW-1:0];
			y_q <= ny[XW-1:0];
			n_q <= n_q + 1'b1;
		end
		if (mul_en) begin
			p_xx_q <= x_q * x_q;
			p_yy_q <= y_q * y_q;
			p_xy_q <= x_q * y_q;
		end
		if (fin && res_free) begin
			res_q.iteration_count <= COUNT_FIELD_W'(fin_count);
			res_q.escaped         <= fin_esc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fin && res_free) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

endmodule

FILE: design/mbe_checker.sv
// Port-level checker for the Mandelbrot escape-time block, bound to the top level.
module mbe_checker #(
	parameter int QUEUE_DEPTH = mbe_pkg::DEF_QUEUE_DEPTH
) (
	input logic             clk,
	input logic             arst_n,
	input logic             pixel_valid,
	input logic             pixel_ready,
	input mbe_pkg::result_t result,
	input logic             result_valid,
	input logic             result_ready
);
	localparam int OW = $clog2(QUEUE_DEPTH + 4) + 1;

	logic [OW-1:0] inflight_q;
	logic          in_xact;
	logic          out_xact;

	assign in_xact  = pixel_valid && pixel_ready;
	assign out_xact = result_valid && result_ready;

	// Count pixels accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_xact && !out_xact) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_xact && !in_xact) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed or dropped while stalled");

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> inflight_q != '0)
		else $error("result presented with no pixel in flight");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= OW'(QUEUE_DEPTH + 3))
		else $error("more pixels in flight than the block can hold");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> inflight_q > OW'(QUEUE_DEPTH))
		else $error("pixel input stalled while front stage or queue had room");

endmodule

bind mandelbrot_escape_time mbe_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_mbe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pixel_valid (pixel_valid),
	.pixel_ready (pixel_ready),
	.result      (result),
	.result_valid(result_valid),
	.result_ready(result_ready)
);

FILE: verif/testbench.sv
// Testbench for mandelbrot_escape_time: random pixel traffic checked against an escape-time predictor.
`timescale 1ns / 100ps

module testbench;
	import mbe_pkg::*;

	localparam int     FRAC           = DEF_FRAC_BITS;
	localparam longint ESC_BOUND      = longint'(1) << (FRAC + 1);
	localparam longint ESC_RADIUS_SQ  = longint'(1) << (2 * FRAC + 2);
	localparam int     REPORT_LIMIT   = 10;
	localparam int     RANDOM_PHASES  = 10;
	localparam int     PHASE_ITEMS    = 63;
	localparam int     HOLD_OFF_LEN   = 2000;

	// Scoreboard: mirrors the register file, predicts one result per accepted pixel
	// and matches results in order.
	class escape_scoreboard;
		longint  origin_re;
		longint  origin_im;
		longint  step_re;
		longint  step_im;
		int      iter_limit;
		result_t pending_results[$];
		int      mismatches;

		function new();
			origin_re  = RST_ORIGIN_REAL;
			origin_im  = RST_ORIGIN_IMAG;
			step_re    = RST_STEP_REAL;
			step_im    = RST_STEP_IMAG;
			iter_limit = RST_MAX_ITER;
			mismatches = 0;
		endfunction

		function void set_register(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
			case (idx)
				REG_ORIGIN_REAL:    origin_re  = $signed(value);
				REG_ORIGIN_IMAG:    origin_im  = $signed(value);
				REG_STEP_REAL:      step_re    = value[STEP_W-1:0];
				REG_STEP_IMAG:      step_im    = value[STEP_W-1:0];
				REG_MAX_ITERATIONS: iter_limit = value[COUNT_FIELD_W-1:0];
				default: ;
			endcase
		endfunction

		function longint saturate_c(longint v);
			if (v > longint'(C_MAX))
				return C_MAX;
			if (v < longint'(C_MIN))
				return C_MIN;
			return v;
		endfunction

		function result_t escape_of(pixel_t p);
			longint  col, row, cre, cim, x, y, nx, ny;
			int      n;
			bit      gone;
			result_t r;
			col  = p.column;
			row  = p.row;
			cre  = saturate_c(origin_re + col * step_re);
			cim  = saturate_c(origin_im + row * step_im);
			x    = 0;
			y    = 0;
			n    = 0;
			gone = 1'b0;
			while (n < iter_limit && !gone) begin
				nx = ((x * x - y * y) >>> FRAC) + cre;
				ny = ((x * y) >>> (FRAC - 1)) + cim;
				if (nx > ESC_BOUND || nx < -ESC_BOUND || ny > ESC_BOUND || ny < -ESC_BOUND ||
				    nx * nx + ny * ny > ESC_RADIUS_SQ) begin
					gone = 1'b1;
				end else begin
					x = nx;
					y = ny;
					n++;
				end
			end
			r.iteration_count = COUNT_FIELD_W'(n);
			r.escaped         = gone;
			return r;
		endfunction

		function void note_pixel(pixel_t p);
			pending_results.push_back(escape_of(p));
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("result with nothing pending: count %0d escaped %0b",
					         got.iteration_count, got.escaped);
				return;
			end
			want = pending_results.pop_front();
			if (got.iteration_count !== want.iteration_count || got.escaped !== want.escaped) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("mismatch: expected count %0d escaped %0b, got count %0d escaped %0b",
					         want.iteration_count, want.escaped,
					         got.iteration_count, got.escaped);
			end
		endfunction
	endclass

	// Clock, reset and every block input start at known values.
	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	pixel_t            pixel        = '0;
	logic              pixel_valid  = 1'b0;
	logic              pixel_ready;
	result_t           result;
	logic              result_valid;
	logic              result_ready = 1'b0;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [ADDR_W-1:0] paddr        = '0;
	logic [DATA_W-1:0] pwdata       = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	escape_scoreboard sb = new();

	longint cycle_count  = 0;
	longint cycle_budget = 20000;
	int     hold_off_request = 0;

	mandelbrot_escape_time u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel        (pixel),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: the budget grows with every pixel offered, sized for the slowest
	// legal run of that pixel at the current iteration limit, several times over.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > cycle_budget) begin
			$display("timeout at cycle %0d", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver: alternate open and stalled runs of random length; an occasional long
	// open run gives stretches with no stall at all. A hold-off request from the
	// stimulus overrides the pattern and is counted down here.
	int hold_left = 0;
	int run_left  = 0;
	bit rx_open   = 1'b0;

	always @(negedge clk) begin
		if (hold_off_request > 0) begin
			hold_left        = hold_off_request;
			hold_off_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			if (run_left == 0) begin
				rx_open = !rx_open;
				if (rx_open)
					run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
					                                       : $urandom_range(1, 16);
				else
					run_left = $urandom_range(1, 6);
			end
			run_left--;
			result_ready <= rx_open;
		end
	end

	// Sample results at the rising edge; every handshake is one result transaction.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
	end

	// All driving tasks start and end at a falling edge.

	// Drop valid for one cycle and scramble the idle payload.
	task automatic pixel_idle();
		pixel_valid <= 1'b0;
		pixel       <= 24'($urandom);
		@(negedge clk);
	endtask

	// Offer one pixel and hold it until the block takes it.
	task automatic send_pixel(input pixel_t p);
		cycle_budget += 4 * (2 * sb.iter_limit + 80);
		pixel       <= p;
		pixel_valid <= 1'b1;
		do @(posedge clk); while (!pixel_ready);
		sb.note_pixel(p);
		@(negedge clk);
	endtask

	// Hold the sender off until every predicted result has come back.
	task automatic wait_results_drained();
		do pixel_idle(); while (sb.pending_results.size() != 0);
	endtask

	// One write transaction: setup cycle, then access cycle until pready.
	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		cycle_budget += 20;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// Drain the block, then load a full view: origin, steps and iteration limit.
	task automatic load_view(input logic [DATA_W-1:0] ore, oim, sre, sim, lim);
		wait_results_drained();
		apb_write(REG_ORIGIN_REAL, ore);
		apb_write(REG_ORIGIN_IMAG, oim);
		apb_write(REG_STEP_REAL, sre);
		apb_write(REG_STEP_IMAG, sim);
		apb_write(REG_MAX_ITERATIONS, lim);
	endtask

	initial begin
		static int         phase_limit [RANDOM_PHASES] =
			'{1, 7, 64, 300, 1000, 33, 150, 16, 500, 65535};
		logic [DATA_W-1:0] ore, oim, sre, sim, lim;
		pixel_t            px;
		int                burst_left;

		// Hold reset, then release it on a falling edge.
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed: default view, corner and alternating-bit pixels.
		send_pixel({12'd0, 12'd0});
		send_pixel({12'd4095, 12'd4095});
		send_pixel({12'hAAA, 12'h555});
		send_pixel({12'h555, 12'hAAA});

		// c = +2.0 sits exactly on the radius: no escape on the first pass, out on the next.
		load_view(32'h2000_0000, 32'h0, 32'h0, 32'h0, 32'd20);
		send_pixel({12'd0, 12'd0});
		// c = -2.0 lands on the fixed point z = 2 and never escapes.
		load_view(32'hE000_0000, 32'h0, 32'h0, 32'h0, 32'd20);
		send_pixel({12'd4095, 12'd4095});
		// c = 1.5 + 1.5i: both parts inside 2.0, escape only by the exact magnitude test.
		load_view(32'h1800_0000, 32'h1800_0000, 32'h0, 32'h0, 32'd20);
		send_pixel({12'd1, 12'd1});

		// Coordinate overflow: origin near the rails, steps with junk above bit 23,
		// iteration limit with junk above bit 15.
		load_view(32'h7FFF_FFF0, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hABCD_0005);
		send_pixel({12'd4095, 12'd0});
		send_pixel({12'd0, 12'd4095});
		send_pixel({12'd4095, 12'd4095});
		send_pixel({12'd1, 12'd1});

		// Zero iteration limit after masking: no pass at all.
		load_view(32'h0, 32'h0, 32'd1311, 32'd1311, 32'hFFFF_0000);
		send_pixel({12'd0, 12'd0});
		send_pixel({12'd4095, 12'd4095});

		// Unmapped register indexes must be ignored.
		wait_results_drained();
		for (int i = int'(REG_MAX_ITERATIONS) + 1; i < 2 ** REG_IDX_W; i++)
			apb_write(REG_IDX_W'(i), $urandom);
		apb_write(REG_MAX_ITERATIONS, 32'h1234_0003);
		send_pixel({12'd0, 12'd0});
		send_pixel({12'd2048, 12'd2048});

		// Largest limit on a point inside the set.
		load_view(32'h0, 32'h0, 32'd1311, 32'd1311, 32'h0000_FFFF);
		send_pixel({12'd0, 12'd0});

		// Random phases, each with its own view and limit.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			sre = $urandom;
			sim = $urandom;
			if (ph == 0) begin
				// Anything goes: full-range origin and steps, saturation is common.
				ore = $urandom;
				oim = $urandom;
			end else if (ph == RANDOM_PHASES - 1) begin
				// Huge limit: keep the window right of the set so pixels escape fast.
				ore = 32'(2 ** 28) + $urandom_range(0, 2 ** 27);
				oim = $urandom_range(0, 2 ** 29) - 32'(2 ** 28);
				sre[STEP_W-1:0] = STEP_W'($urandom_range(0, 2000));
				sim[STEP_W-1:0] = STEP_W'($urandom_range(0, 2000));
			end else begin
				// Window over the interesting part of the plane.
				ore = $urandom_range(0, 738197504) - 32'd603979776;
				oim = $urandom_range(0, 671088640) - 32'd335544320;
				sre[STEP_W-1:0] = STEP_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000)
				                                                      : $urandom_range(0, 200000));
				sim[STEP_W-1:0] = STEP_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000)
				                                                      : $urandom_range(0, 200000));
			end
			lim = $urandom;
			lim[COUNT_FIELD_W-1:0] = COUNT_FIELD_W'(phase_limit[ph]);
			load_view(ore, oim, sre, sim, lim);

			// Stall the receiver for a long stretch while pixels keep coming,
			// so the queue fills and pixel_ready drops.
			if (ph == 0) begin
				hold_off_request = HOLD_OFF_LEN;
				cycle_budget += 2 * HOLD_OFF_LEN;
			end

			burst_left = 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 20);
					// Every third phase streams without gaps.
					if (ph % 3 != 0)
						repeat ($urandom_range(1, 10)) pixel_idle();
				end
				burst_left--;
				// Pause mid-phase until the block is empty.
				if (ph == 5 && i == PHASE_ITEMS / 2)
					wait_results_drained();
				px.column = COORD_FIELD_W'($urandom);
				px.row    = COORD_FIELD_W'($urandom);
				if ($urandom_range(0, 15) == 0)
					px.column = $urandom_range(0, 1) ? '1 : '0;
				if ($urandom_range(0, 15) == 0)
					px.row = $urandom_range(0, 1) ? '1 : '0;
				send_pixel(px);
			end
		end

		// Drain, then give the block time to show any stray result.
		wait_results_drained();
		repeat (40) pixel_idle();

		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
